>>> sv/cle_pkg.sv
`default_nettype none

package cle_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ReqW  = 7;

  localparam logic [ByteW-1:0] CH_BS    = 8'h08;
  localparam logic [ByteW-1:0] CH_DEL   = 8'h7f;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0d;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0a;

  localparam logic ACT_FEED  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO   = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] data;
    logic             last;
    logic             line_ready;
  } res_t;

endpackage

`default_nettype wire

>>> sv/cle_line_ram.sv
`default_nettype none

module cle_line_ram
  import cle_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [ByteW-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [ByteW-1:0] rd_data_r
);

  logic [ByteW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/cle_ctrl.sv
`default_nettype none

module cle_ctrl
  import cle_pkg::*;
#(
  parameter int unsigned LINE_SIZE = 256,
  parameter int unsigned MAX_DRAIN = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             echo_en,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             action,
  input  wire logic [ByteW-1:0] typed_byte,
  input  wire logic [ReqW-1:0]  drain_max,
  output logic                  res_valid,
  output res_t                  res,
  input  wire logic             res_ready
);

  localparam int unsigned LW = $clog2(LINE_SIZE + 1);
  localparam int unsigned AW = $clog2(LINE_SIZE);
  localparam int unsigned NW = $clog2(MAX_DRAIN + 1);

  state_t           state_r, state_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    rpos_r, rpos_nxt;
  logic             cmp_r, cmp_nxt;

  kind_t            sq_kind_r, sq_kind_nxt;
  logic [ByteW-1:0] sq_byte_r, sq_byte_nxt;
  logic             sq_erase_r, sq_erase_nxt;
  logic [1:0]       sq_cnt_r, sq_cnt_nxt;
  logic [1:0]       sq_idx_r, sq_idx_nxt;
  logic             sq_rdy_r, sq_rdy_nxt;

  logic [NW-1:0]    dr_n_r, dr_n_nxt;
  logic [NW-1:0]    dr_iss_r, dr_iss_nxt;
  logic [NW-1:0]    dr_emt_r, dr_emt_nxt;
  logic             dr_rdy_r, dr_rdy_nxt;
  logic             dv_r, dv_nxt;

  logic             mem_wr_en;
  logic [ByteW-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [LW-1:0]    rd_sum;
  logic [ByteW-1:0] rd_data;

  logic [NW-1:0]    want;
  logic [LW-1:0]    avail;
  logic             want_lt;
  logic             is_erase;
  logic             is_nl;
  logic             sq_last;
  logic             dr_last;
  logic             push;
  logic             issue;

  assign want     = (int'(drain_max) > MAX_DRAIN) ? NW'(MAX_DRAIN) : NW'(drain_max);
  assign avail    = len_r - rpos_r;
  assign want_lt  = int'(want) < int'(avail);
  assign is_erase = (typed_byte == CH_BS) || (typed_byte == CH_DEL);
  assign is_nl    = (typed_byte == CH_CR) || (typed_byte == CH_LF);
  assign sq_last  = sq_idx_r == (sq_cnt_r - 2'd1);
  assign dr_last  = dr_emt_r == (dr_n_r - NW'(1));
  assign rd_sum   = rpos_r + LW'(dr_iss_r);

  cle_line_ram #(
    .DEPTH (LINE_SIZE),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (len_r[AW-1:0]),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr   (rd_sum[AW-1:0]),
    .rd_data_r (rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    rpos_nxt     = rpos_r;
    cmp_nxt      = cmp_r;
    sq_kind_nxt  = sq_kind_r;
    sq_byte_nxt  = sq_byte_r;
    sq_erase_nxt = sq_erase_r;
    sq_cnt_nxt   = sq_cnt_r;
    sq_idx_nxt   = sq_idx_r;
    sq_rdy_nxt   = sq_rdy_r;
    dr_n_nxt     = dr_n_r;
    dr_iss_nxt   = dr_iss_r;
    dr_emt_nxt   = dr_emt_r;
    dr_rdy_nxt   = dr_rdy_r;
    dv_nxt       = dv_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    mem_wr_en    = 1'b0;
    mem_wr_data  = typed_byte;
    mem_rd_en    = 1'b0;
    push         = 1'b0;
    issue        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt    = ST_FEED;
          sq_idx_nxt   = 2'd0;
          sq_erase_nxt = 1'b0;
          sq_cnt_nxt   = 2'd1;
          sq_kind_nxt  = KIND_STATUS;
          sq_byte_nxt  = '0;
          sq_rdy_nxt   = 1'b0;
          if (action == ACT_FEED) begin
            if (cmp_r) begin
              sq_rdy_nxt = 1'b1;
            end else if (is_erase) begin
              if (len_r != '0) begin
                len_nxt = len_r - LW'(1);
                if (echo_en) begin
                  sq_kind_nxt  = KIND_ECHO;
                  sq_erase_nxt = 1'b1;
                  sq_cnt_nxt   = 2'd3;
                  sq_byte_nxt  = CH_BS;
                end
              end
            end else if (is_nl) begin
              if (int'(len_r) < LINE_SIZE) begin
                mem_wr_en   = 1'b1;
                mem_wr_data = CH_LF;
                len_nxt     = len_r + LW'(1);
              end
              cmp_nxt    = 1'b1;
              sq_rdy_nxt = 1'b1;
              if (echo_en) begin
                sq_kind_nxt = KIND_ECHO;
                sq_byte_nxt = CH_LF;
              end
            end else if (typed_byte < CH_SPACE) begin
              sq_rdy_nxt = 1'b0;
            end else if (int'(len_r) >= LINE_SIZE - 1) begin
              sq_rdy_nxt = 1'b0;
            end else begin
              mem_wr_en = 1'b1;
              len_nxt   = len_r + LW'(1);
              if (echo_en) begin
                sq_kind_nxt = KIND_ECHO;
                sq_byte_nxt = typed_byte;
              end
            end
          end else begin
            if (!cmp_r || want == '0) begin
              sq_rdy_nxt = cmp_r;
            end else begin
              state_nxt  = ST_DRAIN;
              dr_n_nxt   = want_lt ? want : NW'(avail);
              dr_rdy_nxt = want_lt;
              dr_iss_nxt = '0;
              dr_emt_nxt = '0;
              dv_nxt     = 1'b0;
            end
          end
        end
      end
      ST_FEED: begin
        res_valid      = 1'b1;
        res.kind       = sq_kind_r;
        res.data       = (sq_erase_r && sq_idx_r == 2'd1) ? CH_SPACE : sq_byte_r;
        res.last       = sq_last;
        res.line_ready = sq_rdy_r;
        if (res_ready) begin
          if (sq_last) begin
            state_nxt = ST_IDLE;
          end else begin
            sq_idx_nxt = sq_idx_r + 2'd1;
          end
        end
      end
      ST_DRAIN: begin
        res_valid      = dv_r;
        res.kind       = KIND_LINE;
        res.data       = rd_data;
        res.last       = dr_last;
        res.line_ready = dr_rdy_r;
        push           = dv_r && res_ready;
        issue          = (dr_iss_r != dr_n_r) && (!dv_r || push);
        mem_rd_en      = issue;
        if (issue) begin
          dr_iss_nxt = dr_iss_r + NW'(1);
        end
        dv_nxt = issue || (dv_r && !push);
        if (push) begin
          dr_emt_nxt = dr_emt_r + NW'(1);
          if (dr_last) begin
            state_nxt = ST_IDLE;
            if (dr_rdy_r) begin
              rpos_nxt = rpos_r + LW'(dr_n_r);
            end else begin
              len_nxt  = '0;
              rpos_nxt = '0;
              cmp_nxt  = 1'b0;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      rpos_r  <= '0;
      cmp_r   <= 1'b0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      rpos_r  <= rpos_nxt;
      cmp_r   <= cmp_nxt;
      dv_r    <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_kind_r  <= sq_kind_nxt;
    sq_byte_r  <= sq_byte_nxt;
    sq_erase_r <= sq_erase_nxt;
    sq_cnt_r   <= sq_cnt_nxt;
    sq_idx_r   <= sq_idx_nxt;
    sq_rdy_r   <= sq_rdy_nxt;
    dr_n_r     <= dr_n_nxt;
    dr_iss_r   <= dr_iss_nxt;
    dr_emt_r   <= dr_emt_nxt;
    dr_rdy_r   <= dr_rdy_nxt;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(len_r) <= LINE_SIZE)
    else $error("line length beyond line size");

  a_rpos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_r |-> rpos_r < len_r)
    else $error("read position past end of complete line");

  a_rpos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cmp_r |-> rpos_r == '0)
    else $error("read position nonzero on open line");

  a_read_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && dv_r) |-> dr_iss_r == dr_emt_r + NW'(1))
    else $error("drain read pipeline out of step");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |=> $past(state_r) == ST_IDLE && state_r == ST_FEED)
    else $error("line store written outside feed accept");
`endif

endmodule

`default_nettype wire

>>> sv/canonical_line_editor_unit.sv
`default_nettype none

// Canonical terminal line editor.
// Input channel (in_valid/in_ready): in_action 0 feeds in_typed_byte into
// the line, 1 drains up to in_drain_max stored bytes (capped at MAX_DRAIN).
// Result channel (out_valid/out_ready): one word per echo byte, drained
// byte or status; out_last marks the final word of each input item.
// Config channel (cfg_valid/cfg_ready): cfg_echo_enable turns echo on/off;
// write it only while the block is idle. It is always ready.
// One item is in work at a time; in_ready is high only when idle.
// Feed: after accept the feed state presents 1 to 3 words, one per cycle
// into the output register while out_ready does not stall.
// Drain: the first byte needs a line store read, so it passes through the
// RAM read register before the output register; further bytes follow one
// per cycle from the single read port while out_ready does not stall.
// A stall on out_ready holds the output register and freezes the read
// pipeline; nothing is lost or repeated.
// Reset empties the line and sets echo on. The line store is not cleared;
// no pass is needed since only written entries are read.
module canonical_line_editor_unit
  import cle_pkg::*;
#(
  parameter int unsigned LINE_SIZE = 256,
  parameter int unsigned MAX_DRAIN = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_echo_enable,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_action,
  input  wire logic [ByteW-1:0] in_typed_byte,
  input  wire logic [ReqW-1:0]  in_drain_max,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [1:0]       out_kind,
  output logic      [ByteW-1:0] out_data,
  output logic                  out_last,
  output logic                  out_line_ready
);

  logic echo_r;
  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_r;
  res_t out_word_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b1;
    end else if (cfg_valid) begin
      echo_r <= cfg_echo_enable;
    end
  end

  cle_ctrl #(
    .LINE_SIZE (LINE_SIZE),
    .MAX_DRAIN (MAX_DRAIN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .echo_en    (echo_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (in_action),
    .typed_byte (in_typed_byte),
    .drain_max  (in_drain_max),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // hold the word until taken; refill in the cycle it leaves
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_word_r.kind;
  assign out_data       = out_word_r.data;
  assign out_last       = out_word_r.last;
  assign out_line_ready = out_word_r.line_ready;

endmodule

`default_nettype wire

>>> verif/canonical_line_editor_unit_tb.sv
module canonical_line_editor_unit_tb;
  import cle_pkg::*;

  localparam int LINE_SIZE = 256;
  localparam int MAX_DRAIN = 64;

  typedef struct {
    logic             act;
    logic [ByteW-1:0] key;
    logic [ReqW-1:0]  want;
  } edit_req_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_echo_enable = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_action = ACT_FEED;
  logic [ByteW-1:0] in_typed_byte = '0;
  logic [ReqW-1:0]  in_drain_max = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_kind;
  logic [ByteW-1:0] out_data;
  logic             out_last;
  logic             out_line_ready;

  edit_req_t keystroke_q[$];
  res_t      pending_out_words[$];

  logic [ByteW-1:0] line_mem [LINE_SIZE];
  int   line_len = 0;
  int   rd_pos = 0;
  logic line_done = 1'b0;
  logic echo_on = 1'b1;

  int fail_count = 0;
  int item_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_sender = 1'b0;
  int long_hold_req = 0;
  int long_hold_ack = 0;
  int rx_hold_left = 0;

  canonical_line_editor_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_echo_enable(cfg_echo_enable),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_typed_byte  (in_typed_byte),
    .in_drain_max   (in_drain_max),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data       (out_data),
    .out_last       (out_last),
    .out_line_ready (out_line_ready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic res_t word_of(kind_t k, logic [ByteW-1:0] d);
    res_t w;
    w.kind = k;
    w.data = d;
    w.last = 1'b0;
    w.line_ready = 1'b0;
    return w;
  endfunction

  task automatic model_line_edit(input logic act, input logic [ByteW-1:0] b,
                                 input logic [ReqW-1:0] req);
    res_t gen[$];
    int   want;
    int   n;
    logic rdy;
    rdy = 1'b0;
    if (act == ACT_FEED) begin
      if (line_done) begin
        rdy = 1'b1;
      end else if (b == CH_BS || b == CH_DEL) begin
        if (line_len > 0) begin
          line_len--;
          if (echo_on) begin
            gen.push_back(word_of(KIND_ECHO, CH_BS));
            gen.push_back(word_of(KIND_ECHO, CH_SPACE));
            gen.push_back(word_of(KIND_ECHO, CH_BS));
          end
        end
      end else if (b == CH_CR || b == CH_LF) begin
        if (line_len < LINE_SIZE) begin
          line_mem[line_len] = CH_LF;
          line_len++;
        end
        if (echo_on) gen.push_back(word_of(KIND_ECHO, CH_LF));
        line_done = 1'b1;
        rdy = 1'b1;
      end else if (b >= CH_SPACE && line_len < LINE_SIZE - 1) begin
        line_mem[line_len] = b;
        line_len++;
        if (echo_on) gen.push_back(word_of(KIND_ECHO, b));
      end
    end else if (line_done) begin
      want = (req > MAX_DRAIN) ? MAX_DRAIN : int'(req);
      n = (want < line_len - rd_pos) ? want : line_len - rd_pos;
      for (int i = 0; i < n; i++) gen.push_back(word_of(KIND_LINE, line_mem[rd_pos + i]));
      rd_pos += n;
      if (rd_pos >= line_len) begin
        line_len = 0;
        rd_pos = 0;
        line_done = 1'b0;
      end
      rdy = line_done;
    end
    if (gen.size() == 0) gen.push_back(word_of(KIND_STATUS, 8'h00));
    foreach (gen[i]) gen[i].line_ready = rdy;
    gen[gen.size() - 1].last = 1'b1;
    foreach (gen[i]) pending_out_words.push_back(gen[i]);
  endtask

  always @(posedge clk) begin : drv
    edit_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (keystroke_q.size() != 0 && !hold_sender && $urandom_range(99) >= send_idle_pct) begin
        r = keystroke_q.pop_front();
        in_valid <= 1'b1;
        in_action <= r.act;
        in_typed_byte <= r.key;
        in_drain_max <= r.want;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : rcv
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (long_hold_req != long_hold_ack) begin
      out_ready <= 1'b0;
      rx_hold_left <= 400;
      long_hold_ack <= long_hold_req;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : mon
    res_t exp_w;
    if (!rst_n) begin
      line_len = 0;
      rd_pos = 0;
      line_done = 1'b0;
      echo_on = 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_out_words.size() == 0) begin
          $error("unexpected word: kind %0d data %0h", out_kind, out_data);
          fail_count++;
        end else begin
          exp_w = pending_out_words.pop_front();
          if (out_kind !== exp_w.kind) begin
            $error("kind: expected %0d, got %0d", exp_w.kind, out_kind);
            fail_count++;
          end
          if (out_data !== exp_w.data) begin
            $error("data: expected %0h, got %0h", exp_w.data, out_data);
            fail_count++;
          end
          if (out_last !== exp_w.last) begin
            $error("last: expected %0d, got %0d", exp_w.last, out_last);
            fail_count++;
          end
          if (out_line_ready !== exp_w.line_ready) begin
            $error("line_ready: expected %0d, got %0d", exp_w.line_ready, out_line_ready);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) model_line_edit(in_action, in_typed_byte, in_drain_max);
      if (cfg_valid && cfg_ready) echo_on = cfg_echo_enable;
    end
  end

  task automatic push_feed(input logic [ByteW-1:0] b);
    edit_req_t r;
    r.act = ACT_FEED;
    r.key = b;
    r.want = ReqW'($urandom_range(MAX_DRAIN));
    keystroke_q.push_back(r);
    item_count++;
  endtask

  task automatic push_drain(input int n);
    edit_req_t r;
    r.act = ACT_DRAIN;
    r.key = ByteW'($urandom_range(255));
    r.want = ReqW'(n);
    keystroke_q.push_back(r);
    item_count++;
  endtask

  task automatic make_line(input int body, input int plain_pct);
    logic [ByteW-1:0] b;
    int len;
    int remaining;
    int req;
    int r;
    len = 0;
    if ($urandom_range(9) == 0) push_drain($urandom_range(MAX_DRAIN));
    for (int i = 0; i < body; i++) begin
      r = $urandom_range(99);
      if (r < plain_pct) begin
        b = ByteW'($urandom_range(8'hff, 8'h20));
      end else if (r < plain_pct + (100 - plain_pct) / 2) begin
        b = $urandom_range(1) ? CH_BS : CH_DEL;
      end else begin
        b = ByteW'($urandom_range(8'h1f));
        if (b == CH_CR || b == CH_LF) b = 8'h1b;
      end
      push_feed(b);
      if (b == CH_BS || b == CH_DEL) begin
        if (len > 0) len--;
      end else if (b >= CH_SPACE && len < LINE_SIZE - 1) begin
        len++;
      end
    end
    push_feed($urandom_range(1) ? CH_CR : CH_LF);
    len++;
    if ($urandom_range(4) == 0) push_feed(ByteW'($urandom_range(255)));
    remaining = len;
    while (remaining > 0) begin
      r = $urandom_range(99);
      if (r < 10) req = MAX_DRAIN;
      else if (r < 15) req = 0;
      else if (r < 60) req = $urandom_range((remaining < MAX_DRAIN) ? remaining : MAX_DRAIN, 1);
      else req = $urandom_range(MAX_DRAIN, 1);
      push_drain(req);
      remaining -= (req < remaining) ? req : remaining;
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (keystroke_q.size() != 0 || in_valid || pending_out_words.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_echo(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_echo_enable <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : main
    int mark;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_echo(1'b1);

    push_drain(5);
    push_feed(CH_BS);
    push_feed(CH_DEL);
    push_feed(8'h00);
    push_feed(8'h1f);
    push_feed(8'h41);
    push_feed(CH_SPACE);
    push_feed(8'hff);
    push_feed(8'h80);
    push_feed(8'h7e);
    push_feed(CH_DEL);
    push_feed(CH_BS);
    push_feed(CH_CR);
    push_feed(8'h78);
    push_drain(0);
    push_drain(1);
    push_drain(MAX_DRAIN);
    push_feed(CH_LF);
    push_drain(MAX_DRAIN);
    push_feed(8'h61);
    push_feed(CH_LF);
    push_drain(1);
    push_drain(1);
    push_drain(MAX_DRAIN);
    wait_quiet();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      write_echo(ph[0]);
      @(negedge clk);
      mark = item_count;
      if (ph == 1) make_line(275, 98);
      while (item_count - mark < 8) make_line($urandom_range(12), 72);
      if (ph == 2) long_hold_req++;
      if (ph == 3) begin
        while (keystroke_q.size() > 15) @(negedge clk);
        hold_sender = 1'b1;
        do @(negedge clk);
        while (in_valid || pending_out_words.size() != 0);
        hold_sender = 1'b0;
      end
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
